// ===== rtl/shac_pkg.sv =====
// ----------------------------------------------------------------------------
// shac_pkg
// Shared types, constants and round functions for the SHA-256 compressor.
// ----------------------------------------------------------------------------
package shac_pkg;

  localparam int WORD_W   = 32;
  localparam int BLK_WORDS = 16;
  localparam int ROUNDS   = 64;
  localparam int HASH_WORDS = 8;
  localparam int BQ_DEPTH = 2;

  localparam logic [3:0] POS_LAST = 4'd15;
  localparam logic [5:0] RND_LAST = 6'd63;
  localparam logic [2:0] IDX_LAST = 3'd7;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                        fin;
    logic [BLK_WORDS-1:0][WORD_W-1:0] words;
  } blk_t;

  localparam logic [HASH_WORDS-1:0][WORD_W-1:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(input word_t e, input word_t f, input word_t g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(input word_t a, input word_t b, input word_t c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/shac_front.sv =====
// ----------------------------------------------------------------------------
// shac_front
// Collects message words into a sixteen-word block and hands full blocks on.
// ----------------------------------------------------------------------------
module shac_front import shac_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_push,
  output logic  in_full,
  input  word_t in_message_word,
  input  logic  in_final_word,
  output logic  bq_push,
  input  logic  bq_full,
  output blk_t  bq_data
);

  logic [3:0]  pos_r, pos_nxt;
  word_t       buf_r [BLK_WORDS-1];
  logic        accept;

  assign in_full = (pos_r == POS_LAST) && bq_full;
  assign accept  = in_push && !in_full;
  assign bq_push = accept && (pos_r == POS_LAST);

  // oldest word sits at the low end of the buffer
  always_comb begin
    for (int i = 0; i < BLK_WORDS - 1; i++) begin
      bq_data.words[i] = buf_r[i];
    end
    bq_data.words[BLK_WORDS-1] = in_message_word;
    bq_data.fin = in_final_word;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // word buffer: written by position, no reset
  always_ff @(posedge clk) begin
    if (accept && (pos_r != POS_LAST)) begin
      buf_r[pos_r] <= in_message_word;
    end
  end

endmodule

// ===== rtl/shac_queue.sv =====
// ----------------------------------------------------------------------------
// shac_queue
// Small first-in first-out queue of blocks between front and engine.
// ----------------------------------------------------------------------------
module shac_queue import shac_pkg::*; #(
  parameter int WIDTH = $bits(blk_t),
  parameter int DEPTH = BQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/shac_engine.sv =====
// ----------------------------------------------------------------------------
// shac_engine
// Runs the 64 rounds on one block, updates the chaining value and shifts out
// the digest after a final block.
// ----------------------------------------------------------------------------
module shac_engine import shac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       bq_empty,
  output logic       bq_pop,
  input  blk_t       bq_data,
  output logic       out_empty,
  input  logic       out_pop,
  output word_t      out_digest_word,
  output logic [2:0] out_word_index,
  output logic       out_last_of_digest
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  word_t      w_r     [BLK_WORDS];
  word_t      w_nxt   [BLK_WORDS];
  word_t      v_r     [HASH_WORDS];
  word_t      v_nxt   [HASH_WORDS];
  word_t      chain_r [HASH_WORDS];
  word_t      chain_nxt [HASH_WORDS];
  word_t      dig_r   [HASH_WORDS];
  word_t      dig_nxt [HASH_WORDS];
  logic [2:0] oidx_r, oidx_nxt;
  logic       ovalid_r, ovalid_nxt;
  word_t      t1, t2, w_new;
  logic       do_out_pop;

  assign out_empty          = !ovalid_r;
  assign out_digest_word    = dig_r[0];
  assign out_word_index     = oidx_r;
  assign out_last_of_digest = (oidx_r == IDX_LAST);
  assign do_out_pop         = out_pop && ovalid_r;
  assign bq_pop             = (st_r == ST_IDLE) && !bq_empty;

  always_comb begin
    t1 = v_r[7] + bsig1(v_r[4]) + ch(v_r[4], v_r[5], v_r[6]) + round_k(rnd_r) + w_r[0];
    t2 = bsig0(v_r[0]) + maj(v_r[0], v_r[1], v_r[2]);
    w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);
  end

  always_comb begin
    st_nxt     = st_r;
    rnd_nxt    = rnd_r;
    fin_nxt    = fin_r;
    w_nxt      = w_r;
    v_nxt      = v_r;
    chain_nxt  = chain_r;
    dig_nxt    = dig_r;
    oidx_nxt   = oidx_r;
    ovalid_nxt = ovalid_r;

    if (do_out_pop) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
      oidx_nxt = oidx_r + 3'd1;
      if (oidx_r == IDX_LAST) begin
        ovalid_nxt = 1'b0;
      end
    end

    case (st_r)
      ST_IDLE: begin
        if (!bq_empty) begin
          for (int i = 0; i < BLK_WORDS; i++) begin
            w_nxt[i] = bq_data.words[i];
          end
          v_nxt   = chain_r;
          fin_nxt = bq_data.fin;
          rnd_nxt = '0;
          st_nxt  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < BLK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[BLK_WORDS-1] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == RND_LAST) begin
          st_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!fin_r) begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            chain_nxt[i] = chain_r[i] + v_r[i];
          end
          st_nxt = ST_IDLE;
        end else if (!ovalid_r) begin
          // digest register is free: load it and restart the chain
          for (int i = 0; i < HASH_WORDS; i++) begin
            dig_nxt[i]   = chain_r[i] + v_r[i];
            chain_nxt[i] = IV[i];
          end
          oidx_nxt   = '0;
          ovalid_nxt = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      rnd_r    <= '0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_r[i] <= IV[i];
      end
    end else begin
      st_r     <= st_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
      ovalid_r <= ovalid_nxt;
      chain_r  <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    w_r   <= w_nxt;
    v_r   <= v_nxt;
    dig_r <= dig_nxt;
  end

endmodule

// ===== rtl/sha256_block_compressor.sv =====
// ----------------------------------------------------------------------------
// sha256_block_compressor
// SHA-256 compression of a padded message, sixteen words per block, with the
// eight digest words returned after the block that carries the final mark.
//
//   channel  handshake         payload
//   input    in_push/in_full   in_message_word[31:0], in_final_word
//   result   out_pop/out_empty out_digest_word[31:0], out_word_index[2:0],
//                              out_last_of_digest
//
// A word is taken whenever in_push is high and in_full is low; every sixteenth
// word queues a block. The round engine takes a block through load, 64 rounds
// and chain add, and pops the next block only when back in its idle state.
// in_full rises only when the sixteenth word meets a full block queue; the
// engine waits in its add step while a previous digest is still unread.
// Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module sha256_block_compressor import shac_pkg::*; #(
  parameter int BQ_DEPTH_P = BQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_message_word,
  input  logic        in_final_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_of_digest
);

  logic bq_push, bq_full, bq_pop, bq_empty;
  blk_t bq_wr, bq_rd;

  shac_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_message_word (in_message_word),
    .in_final_word   (in_final_word),
    .bq_push         (bq_push),
    .bq_full         (bq_full),
    .bq_data         (bq_wr)
  );

  shac_queue #(
    .WIDTH ($bits(blk_t)),
    .DEPTH (BQ_DEPTH_P)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (bq_push),
    .full    (bq_full),
    .wr_data (bq_wr),
    .pop     (bq_pop),
    .empty   (bq_empty),
    .rd_data (bq_rd)
  );

  shac_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .bq_empty           (bq_empty),
    .bq_pop             (bq_pop),
    .bq_data            (bq_rd),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_digest_word    (out_digest_word),
    .out_word_index     (out_word_index),
    .out_last_of_digest (out_last_of_digest)
  );

endmodule
